FILE: rtl/core/tlfe_pkg.sv
// ----------------------------------------------------------------------------
// tlfe_pkg: shared constants and types of the lattice field evaluator
// Fixed-point constants, divide-by-constant reciprocals, register codes and
// the pipeline stage map used by the cells and the top level.
// ----------------------------------------------------------------------------
package tlfe_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int Q30_TO_QF     = 30 - FRACTION_BITS;

    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;

    localparam int SINE_TERMS    = 5;
    localparam int EXP_TERMS     = 10;
    localparam int EXP_SQUARINGS = 6;
    localparam int LOG_BITS      = 30;

    // floor(q / D) = (q * M) >> S, exact for any 32-bit q
    localparam logic [32:0] SINE_DIV_MAGIC [SINE_TERMS] = '{
        33'd4997780127, 33'd7635497416, 33'd6544712071, 33'd6871947674, 33'd5726623062
    };
    localparam logic [5:0] SINE_DIV_SHIFT [SINE_TERMS] = '{
        6'd39, 6'd39, 6'd38, 6'd37, 6'd35
    };
    // divisors 10 down to 1
    localparam logic [32:0] EXP_DIV_MAGIC [EXP_TERMS] = '{
        33'd6871947674, 33'd7635497416, 33'd4294967296, 33'd4908534053, 33'd5726623062,
        33'd6871947674, 33'd4294967296, 33'd5726623062, 33'd4294967296, 33'd4294967296
    };
    localparam logic [5:0] EXP_DIV_SHIFT [EXP_TERMS] = '{
        6'd36, 6'd36, 6'd35, 6'd35, 6'd35, 6'd35, 6'd34, 6'd34, 6'd33, 6'd32
    };

    localparam logic signed [34:0] EXTERIOR_PHI = 35'sd1000 <<< FRACTION_BITS;
    localparam logic [48:0]        U_LIMIT      = 49'd32 << FRACTION_BITS;
    localparam logic signed [34:0] PHI_MAX      = 35'sd2147483647;
    localparam logic signed [34:0] PHI_MIN      = -35'sd2147483648;

    // pipeline stage map (index of the register stage)
    localparam int SINE_LAT      = 3 + 2 * SINE_TERMS + 1;
    localparam int ST_THETA      = 0;
    localparam int ST_PROD       = 1;
    localparam int ST_PHASE      = 2;
    localparam int ST_SINE_OUT   = ST_PHASE + SINE_LAT;
    localparam int ST_MUL1       = ST_SINE_OUT + 1;
    localparam int ST_MUL2       = ST_MUL1 + 1;
    localparam int ST_FABS       = ST_MUL2 + 1;
    localparam int ST_WALL       = ST_FABS + 1;
    localparam int ST_URAW       = ST_WALL + 1;
    localparam int ST_U          = ST_URAW + 1;
    localparam int ST_EXP_OUT    = ST_U + 2 * EXP_TERMS;
    localparam int ST_SQ_OUT     = ST_EXP_OUT + EXP_SQUARINGS;
    localparam int ST_Z          = ST_SQ_OUT + 1;
    localparam int ST_LOG_OUT    = ST_Z + LOG_BITS;
    localparam int ST_LN         = ST_LOG_OUT + 1;
    localparam int ST_CORR       = ST_LN + 1;
    localparam int ST_PHI        = ST_CORR + 1;
    localparam int NUM_STAGES    = ST_PHI + 1;

    typedef enum logic [2:0] {
        REG_SURFACE_KIND = 3'd0,
        REG_SPATIAL_FREQ = 3'd1,
        REG_HALF_WALL    = 3'd2,
        REG_SMOOTH_WIDTH = 3'd3,
        REG_SMOOTH_RECIP = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SURF_P      = 2'd0,
        SURF_D      = 2'd1,
        SURF_GYROID = 2'd2
    } t_surface;

    typedef struct packed {
        logic [31:0] z;
        logic [29:0] lg;
    } t_log_state;

endpackage

FILE: rtl/core/tlfe_series_cell.sv
// ----------------------------------------------------------------------------
// tlfe_series_cell: one Horner step of a truncated series
// Computes t' = 1 - floor(floor(x * t / 2^30) / D) in Q30 over two stages.
// ----------------------------------------------------------------------------
module tlfe_series_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [30:0] i_t,
    input  logic [32:0] i_magic,
    input  logic [5:0]  i_shift,
    output logic [31:0] o_x,
    output logic [30:0] o_t
);

    logic [62:0] w_prod;
    logic [64:0] w_quo_full;
    logic [64:0] w_quo;
    logic [31:0] r_xa;
    logic [31:0] r_q;
    logic [31:0] r_xb;
    logic [30:0] r_t;

    assign w_prod     = i_x * i_t;
    assign w_quo_full = r_q * i_magic;
    assign w_quo      = w_quo_full >> i_shift;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa <= i_x;
            r_q  <= w_prod[61:30];
            r_xb <= r_xa;
            r_t  <= tlfe_pkg::Q30_ONE - w_quo[30:0];
        end
    end

    assign o_x = r_xb;
    assign o_t = r_t;

endmodule

FILE: rtl/core/tlfe_sine_lane.sv
// ----------------------------------------------------------------------------
// tlfe_sine_lane: sine of a phase in Q32 turns, result in signed Q30
// Quarter-wave fold, angle scale, a chain of series cells, final scale.
// ----------------------------------------------------------------------------
module tlfe_sine_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sin
);

    localparam int DLY = 2 * tlfe_pkg::SINE_TERMS;

    logic [30:0] w_rr;
    logic [61:0] w_a_prod;
    logic [61:0] w_a2_prod;
    logic [61:0] w_s_prod;
    logic [31:0] w_s;
    logic [30:0] r_rr;
    logic        r_neg0;
    logic [30:0] r_a;
    logic        r_neg1;
    logic [31:0] r_a2;
    logic [30:0] r_a_dly   [DLY+1];
    logic        r_neg_dly [DLY+1];
    logic signed [31:0] r_sin;
    logic [31:0] w_cx [tlfe_pkg::SINE_TERMS+1];
    logic [30:0] w_ct [tlfe_pkg::SINE_TERMS+1];

    // mirror odd quadrants
    assign w_rr = i_phase[30] ? (tlfe_pkg::Q30_ONE - {1'b0, i_phase[29:0]})
                              : {1'b0, i_phase[29:0]};

    assign w_a_prod  = r_rr * tlfe_pkg::HALF_PI_Q30;
    assign w_a2_prod = r_a * r_a;
    assign w_s_prod  = r_a_dly[DLY] * w_ct[tlfe_pkg::SINE_TERMS];
    assign w_s       = w_s_prod[61:30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr         <= w_rr;
            r_neg0       <= i_phase[31];
            r_a          <= w_a_prod[60:30];
            r_neg1       <= r_neg0;
            r_a2         <= w_a2_prod[61:30];
            r_a_dly[0]   <= r_a;
            r_neg_dly[0] <= r_neg1;
            for (int k = 1; k <= DLY; k++) begin
                r_a_dly[k]   <= r_a_dly[k-1];
                r_neg_dly[k] <= r_neg_dly[k-1];
            end
            r_sin <= r_neg_dly[DLY] ? -$signed(w_s) : $signed(w_s);
        end
    end

    assign w_cx[0] = r_a2;
    assign w_ct[0] = tlfe_pkg::Q30_ONE;

    for (genvar gi = 0; gi < tlfe_pkg::SINE_TERMS; gi++) begin : g_term
        tlfe_series_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_x     (w_cx[gi]),
            .i_t     (w_ct[gi]),
            .i_magic (tlfe_pkg::SINE_DIV_MAGIC[gi]),
            .i_shift (tlfe_pkg::SINE_DIV_SHIFT[gi]),
            .o_x     (w_cx[gi+1]),
            .o_t     (w_ct[gi+1])
        );
    end

    assign o_sin = r_sin;

endmodule

FILE: rtl/core/tlfe_square_cell.sv
// ----------------------------------------------------------------------------
// tlfe_square_cell: one truncating Q30 squaring stage
// Raises the exponential of a small argument back toward the full argument.
// ----------------------------------------------------------------------------
module tlfe_square_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_t,
    output logic [30:0] o_t
);

    logic [61:0] w_sq;
    logic [30:0] r_t;

    assign w_sq = i_t * i_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= w_sq[60:30];
        end
    end

    assign o_t = r_t;

endmodule

FILE: rtl/core/tlfe_log_cell.sv
// ----------------------------------------------------------------------------
// tlfe_log_cell: one bit of a base-2 logarithm by repeated squaring
// Square z; when it reaches two, halve it and set this cell's result bit.
// ----------------------------------------------------------------------------
module tlfe_log_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tlfe_pkg::t_log_state i_state,
    input  logic [4:0]           i_bit,
    output tlfe_pkg::t_log_state o_state
);

    logic [63:0]          w_sq;
    logic [32:0]          w_s;
    tlfe_pkg::t_log_state n_state;
    tlfe_pkg::t_log_state r_state;

    assign w_sq = i_state.z * i_state.z;
    assign w_s  = w_sq[62:30];

    always_comb begin
        n_state = i_state;
        if (w_s[32] | w_s[31]) begin
            n_state.z  = w_s[32:1];
            n_state.lg = i_state.lg | (30'd1 << i_bit);
        end else begin
            n_state.z  = w_s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

FILE: rtl/core/tpms_lattice_field_eval_unit.sv
// ----------------------------------------------------------------------------
// tpms_lattice_field_eval_unit: lattice implicit field clipped to a part
// Evaluates a Schwarz P, Schwarz D or gyroid field per voxel, forms the wall
// field and joins it with the part boundary through a smooth maximum.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one voxel per transaction, position and signed
//   boundary distance, all Q16.16. Output stream (m_axis): the field value in
//   tdata and the solid flag in tuser, one transaction per voxel, in order.
//   Configuration: write i_cfg_data to register i_cfg_index while
//   i_cfg_wr_en is high; write only while the block holds no voxel.
//   Throughput: one voxel per cycle while the skid entry is empty, set by a
//   fully pipelined row of cells (sine series, exponential series, squarings,
//   one log bit per cell).
//   Reset: synchronous, active low; drops all voxels in flight and restores
//   the register defaults (P surface, frequency 1.0, no wall offset,
//   smoothing width 1.0, reciprocal 1.0).
//   Stall: an output register plus one skid entry follow the pipeline. The
//   pipeline keeps advancing while a result waits; it holds only once the
//   skid entry fills, and s_axis_tready drops for as long as it is full.
// ----------------------------------------------------------------------------
module tpms_lattice_field_eval_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    // voxel input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // pos_x, pos_y, pos_z, boundary_distance
    // field output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // field_value
    output logic         m_axis_tuser    // is_solid
);

    localparam int F = tlfe_pkg::FRACTION_BITS;

    // ---------------- configuration registers ----------------
    tlfe_pkg::t_surface r_kind;
    logic [30:0] r_omega;
    logic [30:0] r_hwp;
    logic [30:0] r_smf;
    logic [30:0] r_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= tlfe_pkg::SURF_P;
            r_omega <= 31'd65536;
            r_hwp   <= 31'd0;
            r_smf   <= 31'd65536;
            r_recip <= 31'd65536;
        end else if (i_cfg_wr_en) begin
            unique case (tlfe_pkg::t_reg_idx'(i_cfg_index))
                tlfe_pkg::REG_SURFACE_KIND: r_kind  <= tlfe_pkg::t_surface'(i_cfg_data[1:0]);
                tlfe_pkg::REG_SPATIAL_FREQ: r_omega <= i_cfg_data;
                tlfe_pkg::REG_HALF_WALL:    r_hwp   <= i_cfg_data;
                tlfe_pkg::REG_SMOOTH_WIDTH: r_smf   <= i_cfg_data;
                tlfe_pkg::REG_SMOOTH_RECIP: r_recip <= i_cfg_data;
                default: ;  // indexes beyond the map are dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_skid_full;
    logic w_en;
    logic w_accept;
    logic [tlfe_pkg::NUM_STAGES-1:0] r_vld;

    // the whole row advances unless the skid entry is occupied
    assign w_en          = ~r_skid_full;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[tlfe_pkg::NUM_STAGES-2:0], w_accept};
        end
    end

    // ---------------- stage 0: angle theta = omega * p ----------------
    logic signed [31:0] w_pos [3];
    logic signed [31:0] w_dist;
    logic signed [63:0] w_omega_prod [3];
    logic [32:0]        w_smf3;
    logic signed [34:0] w_ext_sum;
    logic [47:0]        r_theta [3];

    assign w_pos[0] = s_axis_tdata[31:0];
    assign w_pos[1] = s_axis_tdata[63:32];
    assign w_pos[2] = s_axis_tdata[95:64];
    assign w_dist   = s_axis_tdata[127:96];

    for (genvar gi = 0; gi < 3; gi++) begin : g_theta
        assign w_omega_prod[gi] = $signed({1'b0, r_omega}) * w_pos[gi];
    end

    // exterior when d < -3 * smf
    assign w_smf3    = 33'({r_smf, 1'b0}) + 33'(r_smf);
    assign w_ext_sum = 35'(w_dist) + $signed({2'b00, w_smf3});

    // side lines: distance, exterior flag, smooth-max base value
    logic signed [31:0] r_d   [tlfe_pkg::ST_FABS+1];
    logic               r_ext [tlfe_pkg::ST_CORR+1];
    logic signed [33:0] r_m   [tlfe_pkg::ST_WALL:tlfe_pkg::ST_CORR];
    logic signed [33:0] w_m;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_theta[k] <= w_omega_prod[k][F+47:F];
            end
            r_d[0]   <= w_dist;
            r_ext[0] <= w_ext_sum[34];
            for (int k = 1; k <= tlfe_pkg::ST_FABS; k++) begin
                r_d[k] <= r_d[k-1];
            end
            for (int k = 1; k <= tlfe_pkg::ST_CORR; k++) begin
                r_ext[k] <= r_ext[k-1];
            end
            r_m[tlfe_pkg::ST_WALL] <= w_m;
            for (int k = tlfe_pkg::ST_WALL + 1; k <= tlfe_pkg::ST_CORR; k++) begin
                r_m[k] <= r_m[k-1];
            end
        end
    end

    // ---------------- stages 1-2: phase in Q32 turns ----------------
    logic [53:0] w_plo [3];
    logic [53:0] w_phi_full [3];
    logic [47:0] w_psum [3];
    logic [53:0] r_plo [3];
    logic [23:0] r_phi_hi [3];
    logic [31:0] r_ph [3];
    logic [31:0] w_cos_ph [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_phase
        assign w_plo[gi]      = r_theta[gi][23:0] * tlfe_pkg::INV_TWO_PI_Q32;
        assign w_phi_full[gi] = r_theta[gi][47:24] * tlfe_pkg::INV_TWO_PI_Q32;
        assign w_psum[gi]     = r_plo[gi][47:0] + {r_phi_hi[gi], 24'd0};
        assign w_cos_ph[gi]   = r_ph[gi] + 32'h4000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_plo[k]    <= w_plo[k];
                r_phi_hi[k] <= w_phi_full[k][23:0];
                r_ph[k]     <= w_psum[k][47:16];
            end
        end
    end

    // ---------------- sine and cosine lanes ----------------
    logic signed [31:0] w_sin [3];
    logic signed [31:0] w_cos [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_trig
        tlfe_sine_lane u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (r_ph[gi]),
            .o_sin   (w_sin[gi])
        );
        tlfe_sine_lane u_cos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_cos_ph[gi]),
            .o_sin   (w_cos[gi])
        );
    end

    // ---------------- surface products ----------------
    logic signed [63:0] w_pcc, w_pss, w_g1, w_g2, w_g3;
    logic signed [33:0] r_pcc, r_pss, r_g1, r_g2, r_g3;
    logic signed [31:0] r_cz, r_sz;
    logic signed [35:0] r_sump, r_sump2, r_sumg;
    logic signed [65:0] w_d1, w_d2;
    logic signed [35:0] r_d1, r_d2;

    assign w_pcc = w_cos[0] * w_cos[1];
    assign w_pss = w_sin[0] * w_sin[1];
    assign w_g1  = w_sin[0] * w_cos[1];
    assign w_g2  = w_sin[1] * w_cos[2];
    assign w_g3  = w_sin[2] * w_cos[0];
    assign w_d1  = r_pcc * r_cz;
    assign w_d2  = r_pss * r_sz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pcc   <= w_pcc[63:30];
            r_pss   <= w_pss[63:30];
            r_g1    <= w_g1[63:30];
            r_g2    <= w_g2[63:30];
            r_g3    <= w_g3[63:30];
            r_cz    <= w_cos[2];
            r_sz    <= w_sin[2];
            r_sump  <= 36'(w_cos[0]) + 36'(w_cos[1]) + 36'(w_cos[2]);
            r_d1    <= w_d1[65:30];
            r_d2    <= w_d2[65:30];
            r_sumg  <= 36'(r_g1) + 36'(r_g2) + 36'(r_g3);
            r_sump2 <= r_sump;
        end
    end

    // ---------------- |f|, wall field, smooth-max base ----------------
    logic signed [35:0] w_f30;
    logic signed [35:0] w_fq;
    logic signed [35:0] w_fabs;
    logic [21:0]        r_fabs;
    logic signed [33:0] w_wall;
    logic signed [33:0] w_nd;
    logic signed [33:0] w_delta_s;
    logic [32:0]        w_delta;
    logic [32:0]        r_delta;

    always_comb begin
        case (r_kind)
            tlfe_pkg::SURF_P:      w_f30 = r_sump2;
            tlfe_pkg::SURF_D:      w_f30 = r_d1 - r_d2;
            tlfe_pkg::SURF_GYROID: w_f30 = r_sumg;
            default:               w_f30 = '0;
        endcase
    end

    assign w_fq   = w_f30 >>> tlfe_pkg::Q30_TO_QF;
    assign w_fabs = w_fq[35] ? -w_fq : w_fq;

    assign w_wall    = $signed({12'd0, r_fabs}) - $signed({3'd0, r_hwp});
    assign w_nd      = -34'(r_d[tlfe_pkg::ST_FABS]);
    assign w_m       = (w_wall > w_nd) ? w_wall : w_nd;
    assign w_delta_s = w_wall + 34'(r_d[tlfe_pkg::ST_FABS]);
    assign w_delta   = w_delta_s[33] ? 33'(-w_delta_s) : 33'(w_delta_s);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fabs  <= w_fabs[21:0];
            r_delta <= w_delta;
        end
    end

    // ---------------- u = |w + d| / smf, clamped at 32 ----------------
    logic [47:0] r_uhi;
    logic [46:0] r_ulo;
    logic [48:0] w_u;
    logic [48:0] w_ucl;
    logic [29:0] r_x;

    assign w_u   = 49'(r_uhi) + 49'(r_ulo[46:F]);
    assign w_ucl = (w_u > tlfe_pkg::U_LIMIT) ? tlfe_pkg::U_LIMIT : w_u;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_uhi <= r_delta[32:F] * r_recip;
            r_ulo <= r_delta[F-1:0] * r_recip;
            // u/64 in Q30
            r_x   <= {w_ucl[21:0], 8'd0};
        end
    end

    // ---------------- exp(-u/64) series, then six squarings ----------------
    logic [31:0] w_ex [tlfe_pkg::EXP_TERMS+1];
    logic [30:0] w_et [tlfe_pkg::EXP_TERMS+1];
    logic [30:0] w_sq [tlfe_pkg::EXP_SQUARINGS+1];

    assign w_ex[0] = {2'd0, r_x};
    assign w_et[0] = tlfe_pkg::Q30_ONE;

    for (genvar gi = 0; gi < tlfe_pkg::EXP_TERMS; gi++) begin : g_exp
        tlfe_series_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_x     (w_ex[gi]),
            .i_t     (w_et[gi]),
            .i_magic (tlfe_pkg::EXP_DIV_MAGIC[gi]),
            .i_shift (tlfe_pkg::EXP_DIV_SHIFT[gi]),
            .o_x     (w_ex[gi+1]),
            .o_t     (w_et[gi+1])
        );
    end

    assign w_sq[0] = w_et[tlfe_pkg::EXP_TERMS];

    for (genvar gi = 0; gi < tlfe_pkg::EXP_SQUARINGS; gi++) begin : g_sq
        tlfe_square_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_t   (w_sq[gi]),
            .o_t   (w_sq[gi+1])
        );
    end

    // ---------------- log2(1 + e), one bit per cell ----------------
    logic [31:0]          r_z;
    tlfe_pkg::t_log_state w_lg [tlfe_pkg::LOG_BITS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z <= 32'(tlfe_pkg::Q30_ONE) + 32'(w_sq[tlfe_pkg::EXP_SQUARINGS]);
        end
    end

    assign w_lg[0].z  = r_z;
    assign w_lg[0].lg = '0;

    for (genvar gi = 0; gi < tlfe_pkg::LOG_BITS; gi++) begin : g_log
        tlfe_log_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_state (w_lg[gi]),
            .i_bit   (5'(tlfe_pkg::LOG_BITS - 1 - gi)),
            .o_state (w_lg[gi+1])
        );
    end

    // ---------------- correction and final value ----------------
    logic [59:0]        w_ln;
    logic [15:0]        r_g;
    logic [46:0]        w_corr;
    logic [30:0]        r_corr;
    logic signed [34:0] w_phi;
    logic signed [34:0] w_phi_sel;
    logic signed [31:0] w_phi_sat;
    logic [31:0]        r_phi;

    // ln(1+e) in Q30, then down to Q.F
    assign w_ln   = w_lg[tlfe_pkg::LOG_BITS].lg * tlfe_pkg::LN2_Q30;
    assign w_corr = r_smf * r_g;
    assign w_phi  = 35'(r_m[tlfe_pkg::ST_CORR]) + $signed({4'd0, r_corr});

    always_comb begin
        w_phi_sel = r_ext[tlfe_pkg::ST_CORR] ? tlfe_pkg::EXTERIOR_PHI : w_phi;
        if (w_phi_sel > tlfe_pkg::PHI_MAX) begin
            w_phi_sat = tlfe_pkg::PHI_MAX[31:0];
        end else if (w_phi_sel < tlfe_pkg::PHI_MIN) begin
            w_phi_sat = tlfe_pkg::PHI_MIN[31:0];
        end else begin
            w_phi_sat = w_phi_sel[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g    <= w_ln[59:30+tlfe_pkg::Q30_TO_QF];
            r_corr <= w_corr[46:F];
            r_phi  <= w_phi_sat;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [31:0] r_skid_data;
    logic        w_take;
    logic        w_last_vld;

    assign w_take     = r_out_valid & m_axis_tready;
    assign w_last_vld = r_vld[tlfe_pkg::ST_PHI];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            // refill the output from the skid entry
            if (w_take) begin
                r_skid_full <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_last_vld;
        end else if (w_last_vld) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_data <= r_phi;
        end else begin
            r_skid_data <= r_phi;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_data[31];

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression of the lattice implicit field evaluator
// Streams voxels through tpms_lattice_field_eval_unit under several register
// settings, predicts each field value and solid flag in fixed point, and
// compares every output transaction in order with the prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_IDX_UNUSED = 3'd5;
    localparam logic [1:0] SURF_UNUSED    = 2'd3;
    localparam longint     ONE_QF         = 64'sd1 << tlfe_pkg::FRACTION_BITS;
    localparam longint     ONE_Q30        = 64'sd1 << 30;
    localparam longint     SINE_DEN [5]   = '{110, 72, 42, 20, 6};
    localparam int         DRAIN_CYCLES   = 120;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] d;
    } t_voxel;

    typedef struct {
        logic [31:0] phi;
        logic        solid;
    } t_field;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [2:0]   i_cfg_index;
    logic [30:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;

    tpms_lattice_field_eval_unit uut (.*);

    // predictor copy of the registers
    logic [1:0]  surf_r;
    logic [30:0] freq_r, wall_r, width_r, recip_r;

    t_voxel voxel_q[$];
    t_field field_q[$];
    int     mismatches;
    int     results_seen;
    bit     in_fire;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] turn_phase(longint p);
        longint          theta;
        longint unsigned prod;
        theta = (longint'(freq_r) * p) >>> tlfe_pkg::FRACTION_BITS;
        prod  = longint'(theta) * 64'd683565276;
        return prod[tlfe_pkg::FRACTION_BITS +: 32];
    endfunction

    // sine of a phase in Q32 turns, Q30 result
    function automatic longint sine_q30(logic [31:0] ph);
        longint r, a, a2, t;
        r = longint'(ph[29:0]);
        if (ph[30]) r = ONE_Q30 - r;
        a  = (r * longint'(tlfe_pkg::HALF_PI_Q30)) >>> 30;
        a2 = (a * a) >>> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 5; i++) t = ONE_Q30 - ((a2 * t) >>> 30) / SINE_DEN[i];
        t = (a * t) >>> 30;
        return ph[31] ? -t : t;
    endfunction

    // ln(1 + exp(-u)), u in Q30
    function automatic longint softplus_q30(longint u30);
        longint x, t, z, lg;
        x  = u30 >>> 6;
        t  = ONE_Q30;
        lg = 0;
        for (int k = 10; k >= 1; k--) t = ONE_Q30 - ((x * t) >>> 30) / k;
        for (int k = 0; k < 6; k++) t = (t * t) >>> 30;
        z = ONE_Q30 + t;
        for (int k = 1; k <= 30; k++) begin
            z = (z * z) >>> 30;
            if (z >= 2 * ONE_Q30) begin
                z  = z >>> 1;
                lg = lg | (64'sd1 << (30 - k));
            end
        end
        return (lg * longint'(tlfe_pkg::LN2_Q30)) >>> 30;
    endfunction

    function automatic t_field predict_field(t_voxel v);
        t_field  res;
        longint  d, smf, phi, f30, f, wall, m, delta, hi, lo, u, g;
        longint  sx, sy, sz, cx, cy, cz;
        logic [31:0] px, py, pz;
        d   = longint'(v.d);
        smf = longint'(width_r);
        if (d < -3 * smf) begin
            phi = 1000 * ONE_QF;
        end else begin
            px = turn_phase(longint'(v.x));
            py = turn_phase(longint'(v.y));
            pz = turn_phase(longint'(v.z));
            sx = sine_q30(px);
            sy = sine_q30(py);
            sz = sine_q30(pz);
            cx = sine_q30(px + 32'h4000_0000);
            cy = sine_q30(py + 32'h4000_0000);
            cz = sine_q30(pz + 32'h4000_0000);
            case (surf_r)
                tlfe_pkg::SURF_P:      f30 = cx + cy + cz;
                tlfe_pkg::SURF_D:      f30 = ((((cx * cy) >>> 30) * cz) >>> 30)
                                           - ((((sx * sy) >>> 30) * sz) >>> 30);
                tlfe_pkg::SURF_GYROID: f30 = ((sx * cy) >>> 30) + ((sy * cz) >>> 30)
                                           + ((sz * cx) >>> 30);
                default:               f30 = 0;
            endcase
            f = f30 >>> tlfe_pkg::Q30_TO_QF;
            if (f < 0) f = -f;
            wall  = f - longint'(wall_r);
            m     = (wall > -d) ? wall : -d;
            delta = wall + d;
            if (delta < 0) delta = -delta;
            hi = delta >>> tlfe_pkg::FRACTION_BITS;
            lo = delta & (ONE_QF - 1);
            u  = hi * longint'(recip_r)
               + ((lo * longint'(recip_r)) >>> tlfe_pkg::FRACTION_BITS);
            if (u > 32 * ONE_QF) u = 32 * ONE_QF;
            u   = u <<< tlfe_pkg::Q30_TO_QF;
            g   = softplus_q30(u) >>> tlfe_pkg::Q30_TO_QF;
            phi = m + ((smf * g) >>> tlfe_pkg::FRACTION_BITS);
        end
        if (phi > 64'sd2147483647) phi = 64'sd2147483647;
        if (phi < -64'sd2147483648) phi = -64'sd2147483648;
        res.phi   = phi[31:0];
        res.solid = (phi < 0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // idle lengths: mostly none or short, a few long
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------
    // driver: offer pending voxels, change at the falling edge
    // ------------------------------------------------------------------
    int tx_gap;
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (tx_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end else if (voxel_q.size() > 0) begin
                t_voxel v;
                v = voxel_q.pop_front();
                s_axis_tdata  <= {v.d, v.z, v.y, v.x};
                s_axis_tvalid <= 1'b1;
                tx_gap        <= gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off while many voxels are still queued, so the pipe backs up
    int  hold_left;
    bit  hold_done;
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 450) begin
            hold_done <= 1'b1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver ready with random stalls
    int rx_gap;
    always @(negedge i_clk) begin
        if (hold_left > 0 || (!hold_done && results_seen >= 450)) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= rx_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each input transaction, check each output one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            t_voxel v;
            v.x = s_axis_tdata[31:0];
            v.y = s_axis_tdata[63:32];
            v.z = s_axis_tdata[95:64];
            v.d = s_axis_tdata[127:96];
            field_q = {field_q, predict_field(v)};
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (field_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result phi=%h solid=%b",
                         $realtime, m_axis_tdata, m_axis_tuser);
            end else begin
                t_field e;
                e = field_q.pop_front();
                if (m_axis_tdata !== e.phi) begin
                    mismatches++;
                    $display("%0t: field_value expected %h actual %h",
                             $realtime, e.phi, m_axis_tdata);
                end
                if (m_axis_tuser !== e.solid) begin
                    mismatches++;
                    $display("%0t: is_solid expected %b actual %b",
                             $realtime, e.solid, m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            tlfe_pkg::REG_SURFACE_KIND: surf_r  = val[1:0];
            tlfe_pkg::REG_SPATIAL_FREQ: freq_r  = val;
            tlfe_pkg::REG_HALF_WALL:    wall_r  = val;
            tlfe_pkg::REG_SMOOTH_WIDTH: width_r = val;
            tlfe_pkg::REG_SMOOTH_RECIP: recip_r = val;
            default: ;
        endcase
    endtask

    // hold until every voxel went out and its result came back
    task automatic wait_idle();
        while (voxel_q.size() > 0 || s_axis_tvalid || field_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_voxel(int x, int y, int z, int d);
        t_voxel v;
        v.x = x; v.y = y; v.z = z; v.d = d;
        voxel_q = {voxel_q, v};
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endfunction

    // boundary distance: mostly within a few smoothing widths of the surface
    function automatic int rand_dist();
        longint span;
        if ($urandom_range(0, 4) == 0) return $urandom;
        span = 4 * longint'(width_r) + ONE_QF;
        if (span > 64'sd2147483647) span = 64'sd2147483647;
        return int'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            push_voxel(rand_coord(), rand_coord(), rand_coord(), rand_dist());
        wait_idle();
    endtask

    task automatic random_config();
        logic [30:0] w;
        w = 31'($urandom_range(6554, 3 * 65536));
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'($urandom_range(0, 2)));
        write_reg(tlfe_pkg::REG_SPATIAL_FREQ, 31'($urandom_range(1, 8 * 65536)));
        write_reg(tlfe_pkg::REG_HALF_WALL, 31'($urandom_range(0, 65536)));
        write_reg(tlfe_pkg::REG_SMOOTH_WIDTH, w);
        write_reg(tlfe_pkg::REG_SMOOTH_RECIP, 31'((64'd1 << 32) / w));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        tx_gap        = 0;
        rx_gap        = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        surf_r  = tlfe_pkg::SURF_P;
        freq_r  = 31'd65536;
        wall_r  = '0;
        width_r = 31'd65536;
        recip_r = 31'd65536;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes on the reset settings, P surface
        push_voxel(0, 0, 0, 0);
        push_voxel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_voxel(32'h0001_921F, 0, 32'hFFFE_6DE1, 0);
        push_voxel(0, 0, 0, -3 * 65536);        // just at the exterior edge
        push_voxel(0, 0, 0, -3 * 65536 - 1);    // exterior
        push_voxel(32'h0003_243F, 32'h0003_243F, 32'h0003_243F, 32'h0000_8000);
        push_voxel(32'hFFFF_FFFF, 1, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_idle();
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(tlfe_pkg::SURF_D));
        push_voxel(32'h0000_C90F, 32'h0000_C90F, 32'h0000_C90F, 0);
        push_voxel(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'h0001_0000);
        push_voxel(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_0000);
        wait_idle();
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(tlfe_pkg::SURF_GYROID));
        push_voxel(32'h0000_C90F, 32'h0001_921F, 32'h0002_5B2F, 0);
        push_voxel(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1000, 32'hFFFF_8000);
        push_voxel(32'hCAFE_F00D, 32'h0BAD_BEEF, 32'h7777_7777, 32'h0000_4000);
        wait_idle();
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(SURF_UNUSED));   // unused code: f is zero
        push_voxel(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_2000);
        push_voxel(0, 0, 0, 32'hFFFF_C000);
        wait_idle();
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(tlfe_pkg::SURF_P));
        write_reg(tlfe_pkg::REG_SMOOTH_RECIP, '0);   // zero reciprocal: ln 2 term
        push_voxel(32'h0001_0000, 0, 0, 32'h0004_0000);
        push_voxel(0, 32'h0002_0000, 0, 32'hFFFF_0000);
        wait_idle();
        write_reg(tlfe_pkg::REG_SMOOTH_RECIP, 31'd65536);
        write_reg(tlfe_pkg::REG_SMOOTH_WIDTH, '0);   // zero width: d < 0 is exterior
        push_voxel(0, 0, 0, -1);
        push_voxel(32'h0000_8000, 0, 0, 0);
        wait_idle();
        write_reg(tlfe_pkg::REG_SMOOTH_WIDTH, 31'd65536);
        write_reg(REG_IDX_UNUSED, 31'h7FFF_FFFF);    // must be ignored
        push_voxel(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 0);
        wait_idle();

        // random: extreme settings first, then typical ones
        write_reg(tlfe_pkg::REG_SPATIAL_FREQ, 31'd1);
        write_reg(tlfe_pkg::REG_HALF_WALL, '0);
        write_reg(tlfe_pkg::REG_SMOOTH_WIDTH, 31'd1);
        write_reg(tlfe_pkg::REG_SMOOTH_RECIP, 31'h7FFF_FFFF);
        random_phase(200);
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(tlfe_pkg::SURF_GYROID));
        write_reg(tlfe_pkg::REG_SPATIAL_FREQ, 31'h7FFF_FFFF);
        write_reg(tlfe_pkg::REG_HALF_WALL, 31'h7FFF_FFFF);
        write_reg(tlfe_pkg::REG_SMOOTH_WIDTH, 31'h7FFF_FFFF);
        write_reg(tlfe_pkg::REG_SMOOTH_RECIP, 31'd1);
        random_phase(200);
        for (int p = 0; p < 6; p++) begin
            random_config();
            random_phase(250);
        end
        write_reg(tlfe_pkg::REG_SURFACE_KIND, 31'(SURF_UNUSED));
        random_phase(100);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && field_q.size() == 0) begin
            $display("tpms_lattice_field_eval_unit regression: pass");
        end else begin
            $display("tpms_lattice_field_eval_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tpms_lattice_field_eval_unit regression: fail");
        $finish;
    end

endmodule
